// ===== design/gl7_pkg.sv =====
// Shared types and constants for the seven-point Laplacian stencil unit.
// Used by the controller, the datapath and the top level; no dependencies.
package gl7_pkg;

  localparam int VAL_W = 32;
  localparam int SUM_W = 36;
  localparam int PRD_W = 53;
  localparam int CFG_W = 32;
  localparam int CIDX_W = 2;
  localparam int NUM_TAPS = 7;
  localparam int TAP_W = 3;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2,
    CFG_INV_SP = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_TAP,
    ST_DRAIN,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_OUT
  } ctrl_state_e;

  localparam logic [TAP_W-1:0] TAP_CENTER = 3'd6;

  typedef struct packed {
    logic                 start;
    logic                 clr_acc;
    logic                 issue;
    logic [TAP_W-1:0]     tap;
    logic [1:0]           cell_sel;
    logic                 mul_lo;
    logic                 mul_hi;
    logic                 load_out;
    logic                 last;
  } gl7_cmd_t;

  typedef struct packed {
    logic [3:0] emit_mask;
    logic       out_free;
  } gl7_sts_t;

endpackage

// ===== design/grid_laplacian_7pt_3d_unit.sv =====
// Top level of the streaming seven-point 3-D Laplacian unit.
// Instantiates gl7_ctrl and gl7_datapath; uses gl7_pkg.
//
// Cells enter in raster order (x fastest, then y, then z), one request per
// cell carrying three signed Q16.16 components. The unit keeps two planes
// plus one cell of history in a single-port-write, single-port-read memory
// of 2*MAX_X*MAX_Y+1 entries, and for every cell it emits the sum of the
// existing face neighbors minus their count times the center, multiplied by
// inv_spacing_sq, rounded to nearest (ties up) and saturated to 32 bits. A
// cell's result leaves on the request that brings its last neighbor, so a
// request yields zero to four results; tlast marks the last one. Each
// completed cell goes through a setup step, seven memory reads (six
// neighbors and the center) on the one read port, a drain step for the
// last read data, the low and high halves of the split 36x17 multiplier,
// and a load into the result register once it is free; that register holds
// a finished result while the next request is taken. Writing any size
// register restarts the frame at the origin; sizes are clamped to
// [2, MAX_X], [2, MAX_Y] and [2, 4095]. The history memory needs no clearing.
module grid_laplacian_7pt_3d_unit
  import gl7_pkg::*;
#(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int COMPONENTS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [95:0]       s_tdata,   // value_a, value_b, value_c
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [119:0]      m_tdata,   // lap_a, lap_b, lap_c, cell_x, cell_y, cell_z
  output logic              m_tlast,   // run_end
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  gl7_cmd_t cmd;
  gl7_sts_t sts;

  gl7_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gl7_datapath #(
    .MAX_X      (MAX_X),
    .MAX_Y      (MAX_Y),
    .COMPONENTS (COMPONENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_o  (m_tdata),
    .out_last_o  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // A result is only loaded when the result register can take it.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded into a full output register");

  // After the last result of a request the unit takes new requests again.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && cmd.last) |=> s_tready)
    else $error("unit not ready after last result");

  // Memory reads never overlap a result load.
  a_issue_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !cmd.load_out && !s_tready)
    else $error("memory read issued outside the tap sequence");
`endif

endmodule

// ===== design/gl7_ctrl.sv =====
// Sequencer for the stencil unit: walks the cells that one request completes.
// Depends on gl7_pkg; drives the datapath through gl7_cmd_t only.
module gl7_ctrl
  import gl7_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gl7_sts_t sts_i,
  output gl7_cmd_t cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [3:0]       mask_q, mask_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic [1:0]       sel;
  logic [3:0]       rest;

  always_comb begin
    sel = 2'd0;
    if (mask_q[0]) begin
      sel = 2'd0;
    end else if (mask_q[1]) begin
      sel = 2'd1;
    end else if (mask_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    rest = mask_q & ~(4'b0001 << sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mask_q  <= '0;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      tap_q   <= tap_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mask_d     = mask_q;
    tap_d      = tap_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.tap      = tap_q;
    cmd_o.cell_sel = sel;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          mask_d = sts_i.emit_mask;
          if (sts_i.emit_mask != 4'd0) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.clr_acc = 1'b1;
        tap_d = '0;
        state_d = ST_TAP;
      end
      ST_TAP: begin
        cmd_o.issue = 1'b1;
        if (tap_q == TAP_CENTER) begin
          state_d = ST_DRAIN;
        end else begin
          tap_d = tap_q + 3'd1;
        end
      end
      ST_DRAIN:  state_d = ST_MUL_LO;
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.last = (rest == 4'd0);
          mask_d = rest;
          state_d = (rest == 4'd0) ? ST_IDLE : ST_SETUP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/gl7_datapath.sv =====
// Datapath of the stencil unit: history memory, positions, accumulators,
// split multiplier, rounding, saturation and the result register. Uses gl7_pkg.
module gl7_datapath
  import gl7_pkg::*;
#(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int COMPONENTS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gl7_cmd_t            cmd_i,
  output gl7_sts_t            sts_o,
  input  logic [95:0]         in_data_i,
  input  logic                cfg_we_i,
  input  logic [CIDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [119:0]        out_data_o,
  output logic                out_last_o
);

  localparam int DEPTH = 2 * MAX_X * MAX_Y + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int OW    = AW + 3;
  localparam int XW    = $clog2(MAX_X);
  localparam int YW    = $clog2(MAX_Y);
  localparam int SXW   = $clog2(MAX_X + 1);
  localparam int SYW   = $clog2(MAX_Y + 1);
  localparam int PW    = SXW + SYW;
  localparam int MW    = COMPONENTS * VAL_W;

  // Configuration and position state.
  logic [6:0]       size_x_q, size_y_q;
  logic [11:0]      size_z_q;
  logic [CFG_W-1:0] inv_sp_q;
  logic [XW-1:0]    pos_x_q, cur_x_q;
  logic [YW-1:0]    pos_y_q, cur_y_q;
  logic [11:0]      pos_z_q, cur_z_q;
  logic [AW-1:0]    wr_q, wr_inc;
  logic             out_vld_q;

  logic [SXW-1:0] sx;
  logic [SYW-1:0] sy;
  logic [11:0]    sz;
  logic [PW-1:0]  plane;

  always_comb begin
    if (size_x_q < 7'd2) begin
      sx = SXW'(2);
    end else if (32'(size_x_q) > MAX_X) begin
      sx = SXW'(MAX_X);
    end else begin
      sx = SXW'(size_x_q);
    end
    if (size_y_q < 7'd2) begin
      sy = SYW'(2);
    end else if (32'(size_y_q) > MAX_Y) begin
      sy = SYW'(MAX_Y);
    end else begin
      sy = SYW'(size_y_q);
    end
    sz = (size_z_q < 12'd2) ? 12'd2 : size_z_q;
    plane = PW'(sx) * PW'(sy);
  end

  // Position of the arriving cell, restarted when it lies outside the frame.
  logic          wrap;
  logic [XW-1:0] ax;
  logic [YW-1:0] ay;
  logic [11:0]   az;
  logic          x_end, y_end, z_end;

  always_comb begin
    wrap = (SXW'(pos_x_q) >= sx) || (SYW'(pos_y_q) >= sy) || (pos_z_q >= sz);
    ax = wrap ? '0 : pos_x_q;
    ay = wrap ? '0 : pos_y_q;
    az = wrap ? '0 : pos_z_q;
    x_end = (SXW'(ax) == sx - SXW'(1));
    y_end = (SYW'(ay) == sy - SYW'(1));
    z_end = (az == sz - 12'd1);
    sts_o.emit_mask[0] = (az != 12'd0);
    sts_o.emit_mask[1] = z_end && (ay != '0);
    sts_o.emit_mask[2] = z_end && y_end && (ax != '0);
    sts_o.emit_mask[3] = z_end && y_end && x_end;
    sts_o.out_free     = !out_vld_q || out_ready_i;
    wr_inc = (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 7'd64;
      size_y_q <= 7'd64;
      size_z_q <= 12'd64;
      inv_sp_q <= 32'd65536;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      pos_z_q  <= '0;
      wr_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SIZE_X: size_x_q <= cfg_data_i[6:0];
        CFG_SIZE_Y: size_y_q <= cfg_data_i[6:0];
        CFG_SIZE_Z: size_z_q <= cfg_data_i[11:0];
        CFG_INV_SP: inv_sp_q <= cfg_data_i;
        default: ;
      endcase
      if (cfg_idx_e'(cfg_idx_i) != CFG_INV_SP) begin
        pos_x_q <= '0;
        pos_y_q <= '0;
        pos_z_q <= '0;
      end
    end else if (cmd_i.start) begin
      wr_q <= wr_inc;
      if (x_end) begin
        pos_x_q <= '0;
        if (y_end) begin
          pos_y_q <= '0;
          pos_z_q <= z_end ? 12'd0 : az + 12'd1;
        end else begin
          pos_y_q <= ay + YW'(1);
          pos_z_q <= az;
        end
      end else begin
        pos_x_q <= ax + XW'(1);
        pos_y_q <= ay;
        pos_z_q <= az;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_x_q <= ax;
      cur_y_q <= ay;
      cur_z_q <= az;
    end
  end

  // Cell being finished and its distance back from the newest entry.
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [11:0]   cz;
  logic [AW-1:0] back;
  logic [NUM_TAPS-1:0] exist;

  always_comb begin
    cx = cur_x_q;
    cy = cur_y_q;
    cz = cur_z_q;
    back = '0;
    case (cmd_i.cell_sel)
      2'd0: begin
        cz = cur_z_q - 12'd1;
        back = AW'(plane);
      end
      2'd1: begin
        cy = cur_y_q - YW'(1);
        back = AW'(sx);
      end
      2'd2: begin
        cx = cur_x_q - XW'(1);
        back = AW'(1);
      end
      default: back = '0;
    endcase
    exist[0] = (cx != '0);
    exist[1] = (SXW'(cx) != sx - SXW'(1));
    exist[2] = (cy != '0);
    exist[3] = (SYW'(cy) != sy - SYW'(1));
    exist[4] = (cz != 12'd0);
    exist[5] = (cz != sz - 12'd1);
    exist[6] = 1'b1;
  end

  // Read address of one tap, modulo the history depth.
  logic signed [OW-1:0] off, raw;
  logic [AW-1:0]        rd_addr;

  always_comb begin
    case (cmd_i.tap)
      3'd0:    off = $signed(OW'(back)) + OW'(1);
      3'd1:    off = $signed(OW'(back)) - OW'(1);
      3'd2:    off = $signed(OW'(back)) + $signed(OW'(sx));
      3'd3:    off = $signed(OW'(back)) - $signed(OW'(sx));
      3'd4:    off = $signed(OW'(back)) + $signed(OW'(plane));
      3'd5:    off = $signed(OW'(back)) - $signed(OW'(plane));
      default: off = $signed(OW'(back));
    endcase
    raw = $signed(OW'(wr_q)) - off;
    if (raw < 0) begin
      rd_addr = AW'(raw + OW'(DEPTH));
    end else if (raw >= OW'(DEPTH)) begin
      rd_addr = AW'(raw - OW'(DEPTH));
    end else begin
      rd_addr = AW'(raw);
    end
  end

  // History memory: one write port, one registered read port.
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mem[wr_inc] <= in_data_i[MW-1:0];
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  logic             rd_vld_q;
  logic [TAP_W-1:0] rd_tap_q;
  logic             rd_use_q;
  logic [2:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_tap_q <= cmd_i.tap;
      rd_use_q <= exist[cmd_i.tap];
    end
  end

  // Per-component accumulation, split multiply and rounding.
  logic signed [SUM_W-1:0] sum_q  [COMPONENTS];
  logic signed [PRD_W-1:0] plo_q  [COMPONENTS];
  logic signed [PRD_W-1:0] phi_q  [COMPONENTS];
  logic signed [VAL_W-1:0] lap_q  [COMPONENTS];
  logic signed [SUM_W-1:0] ctr_prod [COMPONENTS];
  logic signed [PRD_W+1:0] rnd [COMPONENTS];
  logic signed [VAL_W-1:0] sat [COMPONENTS];
  logic signed [16:0]      k_mul;

  always_comb begin
    k_mul = $signed({1'b0, (cmd_i.mul_lo ? inv_sp_q[15:0] : inv_sp_q[31:16])});
    for (int c = 0; c < COMPONENTS; c++) begin
      ctr_prod[c] = SUM_W'($signed(rd_data_q[c*VAL_W +: VAL_W])) *
                    $signed({1'b0, cnt_q});
      rnd[c] = (PRD_W+2)'(phi_q[c]) +
               ((PRD_W+2)'(plo_q[c]) + (PRD_W+2)'(32768) >>> 16);
      if (rnd[c] > (PRD_W+2)'(2147483647)) begin
        sat[c] = 32'sh7FFFFFFF;
      end else if (rnd[c] < -(PRD_W+2)'(64'sd2147483648)) begin
        sat[c] = 32'sh80000000;
      end else begin
        sat[c] = VAL_W'(rnd[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) begin
      cnt_q <= '0;
    end else if (rd_vld_q && rd_use_q && (rd_tap_q != TAP_CENTER)) begin
      cnt_q <= cnt_q + 3'd1;
    end
    for (int c = 0; c < COMPONENTS; c++) begin
      if (cmd_i.clr_acc) begin
        sum_q[c] <= '0;
      end else if (rd_vld_q && rd_use_q) begin
        if (rd_tap_q == TAP_CENTER) begin
          sum_q[c] <= sum_q[c] - ctr_prod[c];
        end else begin
          sum_q[c] <= sum_q[c] + SUM_W'($signed(rd_data_q[c*VAL_W +: VAL_W]));
        end
      end
      if (cmd_i.mul_lo) begin
        plo_q[c] <= sum_q[c] * k_mul;
      end
      if (cmd_i.mul_hi) begin
        phi_q[c] <= sum_q[c] * k_mul;
      end
      if (cmd_i.load_out) begin
        lap_q[c] <= sat[c];
      end
    end
  end

  // Result register.
  logic [5:0]  ox_q, oy_q;
  logic [11:0] oz_q;
  logic        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      ox_q   <= 6'(cx);
      oy_q   <= 6'(cy);
      oz_q   <= cz;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_last_o     = last_q;

  for (genvar g = 0; g < 3; g++) begin : g_lap
    if (g < COMPONENTS) begin : g_used
      assign out_data_o[g*VAL_W +: VAL_W] = lap_q[g];
    end else begin : g_zero
      assign out_data_o[g*VAL_W +: VAL_W] = '0;
    end
  end
  assign out_data_o[101:96]  = ox_q;
  assign out_data_o[107:102] = oy_q;
  assign out_data_o[119:108] = oz_q;

endmodule
